// File: sv/ssti_pkg.sv
// ssti_pkg: shared constants, status codes and pipeline side-band types
// for the swept sphere time-of-impact pipeline. No dependencies.
`default_nettype none

package ssti_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OVERLAP  = 2'd0,
    ST_SEPARATE = 2'd1,
    ST_IMPACT   = 2'd2,
    ST_MISS     = 2'd3
  } status_e;

  // Square root unit: 160-bit radicand, one root bit per stage
  localparam int unsigned RAD_W    = 160;
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned SQ_STEPS = ROOT_W;
  localparam int unsigned SQREM_W  = ROOT_W + 3;

  // Divider: 82-bit numerator, 65-bit divisor, 32 quotient bits
  localparam int unsigned NUM_W    = 82;
  localparam int unsigned DEN_W    = 65;
  localparam int unsigned QUO_W    = 32;
  localparam int unsigned DV_STEPS = QUO_W;
  localparam int unsigned LANES    = 3;

  localparam logic [31:0] TIME_ONE  = 32'h0001_0000;
  localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // Side-band carried alongside the square root stages
  typedef struct packed {
    status_e           status;
    logic [31:0]       time_pre;
    logic              ss_zero;
    logic [2:0]        neg;
    logic [2:0][62:0]  md;
    logic [63:0]       a;
    logic [63:0]       nb;
  } sq_side_t;

  // Side-band carried alongside the divider stages
  typedef struct packed {
    status_e     status;
    logic [31:0] time_pre;
    logic        ss_zero;
    logic [2:0]  neg;
    logic [2:0]  sat;
  } dv_side_t;

  // Apply sign and clamp a saturated magnitude to the signed 32-bit range
  function automatic logic [31:0] signed_clamp(input logic [31:0] q, input logic neg);
    logic [31:0] m;
    if (neg) begin
      m = (q > NEG_LIMIT) ? NEG_LIMIT : q;
      return 32'd0 - m;
    end
    return (q > POS_LIMIT) ? POS_LIMIT : q;
  endfunction

endpackage

`default_nettype wire

// File: sv/ssti_in_if.sv
// ssti_in_if: valid/ready channel carrying one sphere pair.
// No dependencies.
`default_nettype none

interface ssti_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] rel_pos_x;
  logic [31:0] rel_pos_y;
  logic [31:0] rel_pos_z;
  logic [31:0] rel_vel_x;
  logic [31:0] rel_vel_y;
  logic [31:0] rel_vel_z;
  logic [30:0] diameter_a;
  logic [30:0] diameter_b;
  logic [31:0] prior_time;

  modport source (
    output valid, rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z,
           diameter_a, diameter_b, prior_time,
    input  ready
  );
  modport sink (
    input  valid, rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z,
           diameter_a, diameter_b, prior_time,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/ssti_out_if.sv
// ssti_out_if: valid/ready channel carrying one time-of-impact result.
// No dependencies.
`default_nettype none

interface ssti_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] contact_x;
  logic [31:0] contact_y;
  logic [31:0] contact_z;
  logic [31:0] impact_time;

  modport source (
    output valid, status, contact_x, contact_y, contact_z, impact_time,
    input  ready
  );
  modport sink (
    input  valid, status, contact_x, contact_y, contact_z, impact_time,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/swept_sphere_time_of_impact.sv
// Swept sphere-sphere time of impact. Fully pipelined: one sphere pair per
// cycle while no result is held on the output (6 arithmetic stages, 80
// square-root stages, 2 setup stages, 32 divider stages, 1 output register).
// Depth is set by the bit-per-stage square root and divider. The whole pipe
// freezes while a result waits on the output; it never drops or repeats one.
// Depends on ssti_pkg, ssti_in_if, ssti_out_if.
`default_nettype none

module swept_sphere_time_of_impact
  import ssti_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ssti_in_if.sink     in_i,
  ssti_out_if.source  out_o
);

  typedef struct packed {
    logic             c4neg;
    logic             bneg;
    logic [63:0]      a;
    logic [63:0]      ss;
    logic [63:0]      nb;
    logic [2:0][62:0] md;
    logic [2:0]       neg;
    logic [31:0]      prior;
  } fr_t;

  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // ---------------- Stage 1: component products ----------------
  logic [2:0][31:0] s_in, v_in;
  logic [31:0]      sumd;
  assign s_in = {in_i.rel_pos_z, in_i.rel_pos_y, in_i.rel_pos_x};
  assign v_in = {in_i.rel_vel_z, in_i.rel_vel_y, in_i.rel_vel_x};
  assign sumd = {1'b0, in_i.diameter_a} + {1'b0, in_i.diameter_b};

  logic             v1_q;
  logic [2:0][63:0] pv1_d, pv1_q, pb1_d, pb1_q, ps1_d, ps1_q;
  logic [2:0][62:0] md1_d, md1_q;
  logic [2:0]       neg1_q;
  logic [63:0]      sq1_q;
  logic [31:0]      prior1_q;

  always_comb begin
    logic [31:0] mag;
    for (int i = 0; i < 3; i++) begin
      pv1_d[i] = 64'($signed(v_in[i]) * $signed(v_in[i]));
      pb1_d[i] = 64'($signed(v_in[i]) * $signed(s_in[i]));
      ps1_d[i] = 64'($signed(s_in[i]) * $signed(s_in[i]));
      mag      = s_in[i][31] ? (32'd0 - s_in[i]) : s_in[i];
      md1_d[i] = 63'(mag) * 63'(in_i.diameter_a);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pv1_q    <= pv1_d;
      pb1_q    <= pb1_d;
      ps1_q    <= ps1_d;
      md1_q    <= md1_d;
      neg1_q   <= {s_in[2][31], s_in[1][31], s_in[0][31]};
      sq1_q    <= 64'(sumd) * 64'(sumd);
      prior1_q <= in_i.prior_time;
    end
  end

  // ---------------- Stage 2: dot products ----------------
  logic             v2_q;
  logic [63:0]      a2_q, ss2_q, sq2_q;
  logic [65:0]      b2_q;
  logic [2:0][62:0] md2_q;
  logic [2:0]       neg2_q;
  logic [31:0]      prior2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a2_q     <= pv1_q[0] + pv1_q[1] + pv1_q[2];
      ss2_q    <= ps1_q[0] + ps1_q[1] + ps1_q[2];
      b2_q     <= {{2{pb1_q[0][63]}}, pb1_q[0]} + {{2{pb1_q[1][63]}}, pb1_q[1]}
                + {{2{pb1_q[2][63]}}, pb1_q[2]};
      sq2_q    <= sq1_q;
      md2_q    <= md1_q;
      neg2_q   <= neg1_q;
      prior2_q <= prior1_q;
    end
  end

  // ---------------- Stage 3: c = 4ss - (da+db)^2, -b ----------------
  logic        v3_q;
  fr_t         f3_d, f3_q;
  logic [65:0] c4u3_q;
  logic [66:0] c4_w;
  logic [65:0] nb_w;

  assign c4_w = {1'b0, ss2_q, 2'b00} - {3'b000, sq2_q};
  assign nb_w = 66'd0 - b2_q;

  always_comb begin
    f3_d.c4neg = c4_w[66];
    f3_d.bneg  = b2_q[65];
    f3_d.a     = a2_q;
    f3_d.ss    = ss2_q;
    f3_d.nb    = nb_w[63:0];
    f3_d.md    = md2_q;
    f3_d.neg   = neg2_q;
    f3_d.prior = prior2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f3_q   <= f3_d;
      c4u3_q <= c4_w[65:0];
    end
  end

  // ---------------- Stage 4: partial products of b^2 and a*c ----------------
  logic        v4_q;
  fr_t         f4_q;
  logic [63:0] hh4_q, hl4_q, ll4_q;
  logic [63:0] a1c1_q, a1c0_q, a0c1_q, a0c0_q;
  logic [33:0] a1c2_q, a0c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f4_q   <= f3_q;
      hh4_q  <= 64'(f3_q.nb[63:32]) * 64'(f3_q.nb[63:32]);
      hl4_q  <= 64'(f3_q.nb[63:32]) * 64'(f3_q.nb[31:0]);
      ll4_q  <= 64'(f3_q.nb[31:0])  * 64'(f3_q.nb[31:0]);
      a1c1_q <= 64'(f3_q.a[63:32]) * 64'(c4u3_q[63:32]);
      a1c0_q <= 64'(f3_q.a[63:32]) * 64'(c4u3_q[31:0]);
      a0c1_q <= 64'(f3_q.a[31:0])  * 64'(c4u3_q[63:32]);
      a0c0_q <= 64'(f3_q.a[31:0])  * 64'(c4u3_q[31:0]);
      a1c2_q <= 34'(f3_q.a[63:32]) * 34'(c4u3_q[65:64]);
      a0c2_q <= 34'(f3_q.a[31:0])  * 34'(c4u3_q[65:64]);
    end
  end

  // ---------------- Stage 5: sum partial products ----------------
  logic         v5_q;
  fr_t          f5_q;
  logic [127:0] bsq5_q;
  logic [129:0] ac5_q;
  logic [64:0]  t64, t32;

  assign t64 = {1'b0, a1c1_q} + {31'b0, a0c2_q};
  assign t32 = {1'b0, a1c0_q} + {1'b0, a0c1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f5_q   <= f4_q;
      bsq5_q <= {hh4_q, 64'b0} + {31'b0, hl4_q, 33'b0} + {64'b0, ll4_q};
      ac5_q  <= {a1c2_q, 96'b0} + {1'b0, t64, 64'b0} + {33'b0, t32, 32'b0}
              + {66'b0, a0c0_q};
    end
  end

  // ---------------- Stage 6: discriminant, classification ----------------
  logic           sq_v_q    [SQ_STEPS+1];
  logic [SQREM_W-1:0] sq_rem_q  [SQ_STEPS+1];
  logic [ROOT_W-1:0]  sq_root_q [SQ_STEPS+1];
  logic [RAD_W-1:0]   sq_rad_q  [SQ_STEPS+1];
  sq_side_t       sq_side_q [SQ_STEPS+1];

  logic [130:0]   d4_w;
  logic [32:0]    tsep_w;
  sq_side_t       side6_d;
  logic [RAD_W-1:0] rad6_d;

  assign d4_w   = {1'b0, bsq5_q, 2'b00} - {1'b0, ac5_q};
  assign tsep_w = {1'b0, f5_q.prior} + {1'b0, TIME_ONE};

  always_comb begin
    side6_d.ss_zero = (f5_q.ss == 64'd0);
    side6_d.neg     = f5_q.neg;
    side6_d.md      = f5_q.md;
    side6_d.a       = f5_q.a;
    side6_d.nb      = f5_q.nb;
    side6_d.time_pre = 32'd0;
    rad6_d          = {64'b0, f5_q.ss, 32'b0};
    if (f5_q.c4neg) begin
      side6_d.status = ST_OVERLAP;
    end else if (!f5_q.bneg) begin
      side6_d.status   = ST_SEPARATE;
      side6_d.time_pre = tsep_w[32] ? TIME_MAX : tsep_w[31:0];
    end else if (d4_w[130]) begin
      side6_d.status   = ST_MISS;
      side6_d.time_pre = f5_q.prior;
    end else begin
      side6_d.status = ST_IMPACT;
      rad6_d         = {d4_w[127:0], 32'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (adv) begin
      sq_v_q[0] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_side_q[0] <= side6_d;
      sq_rad_q[0]  <= rad6_d;
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  // ---------------- Square root: one root bit per stage ----------------
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [SQREM_W-1:0] remx, trial;
    logic               ge;

    assign remx  = {sq_rem_q[k][SQREM_W-3:0], sq_rad_q[k][RAD_W-1-2*k -: 2]};
    assign trial = {1'b0, sq_root_q[k], 2'b01};
    assign ge    = (remx >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[k+1]  <= ge ? (remx - trial) : remx;
        sq_root_q[k+1] <= {sq_root_q[k][ROOT_W-2:0], ge};
        sq_rad_q[k+1]  <= sq_rad_q[k];
        sq_side_q[k+1] <= sq_side_q[k];
      end
    end
  end

  // ---------------- Divider operand setup ----------------
  logic                    vn_q;
  logic [LANES-1:0][NUM_W-1:0] numn_d, numn_q;
  logic [LANES-1:0][DEN_W-1:0] denn_d, denn_q;
  sq_side_t                sidn_q;
  sq_side_t                sq_end;
  logic [ROOT_W-1:0]       root_end;

  assign sq_end   = sq_side_q[SQ_STEPS];
  assign root_end = sq_root_q[SQ_STEPS];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      numn_d[i] = {3'b0, sq_end.md[i], 16'b0};
      denn_d[i] = root_end[DEN_W-1:0];
    end
    // Impact time reuses lane 0: (2^17 * -b - root) / 2a
    if (sq_end.status == ST_IMPACT) begin
      numn_d[0] = {1'b0, sq_end.nb, 17'b0} - {2'b0, root_end};
      denn_d[0] = {sq_end.a, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (adv) begin
      vn_q <= sq_v_q[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numn_q <= numn_d;
      denn_q <= denn_d;
      sidn_q <= sq_end;
    end
  end

  // ---------------- Divider: saturation check, then one bit per stage ----------------
  logic                        dv_v_q    [DV_STEPS+1];
  logic [LANES-1:0][DEN_W-1:0] dv_rem_q  [DV_STEPS+1];
  logic [LANES-1:0][DEN_W-1:0] dv_den_q  [DV_STEPS+1];
  logic [LANES-1:0][QUO_W-1:0] dv_nlo_q  [DV_STEPS+1];
  logic [LANES-1:0][QUO_W-1:0] dv_quo_q  [DV_STEPS+1];
  dv_side_t                    dv_side_q [DV_STEPS+1];

  dv_side_t                    sidc_d;
  logic [LANES-1:0][DEN_W-1:0] remc_d;

  always_comb begin
    sidc_d.status   = sidn_q.status;
    sidc_d.time_pre = sidn_q.time_pre;
    sidc_d.ss_zero  = sidn_q.ss_zero;
    sidc_d.neg      = sidn_q.neg;
    for (int i = 0; i < LANES; i++) begin
      remc_d[i]     = DEN_W'(numn_q[i][NUM_W-1:QUO_W]);
      sidc_d.sat[i] = (remc_d[i] >= denn_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= vn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_side_q[0] <= sidc_d;
      dv_rem_q[0]  <= remc_d;
      dv_den_q[0]  <= denn_q;
      for (int i = 0; i < LANES; i++) begin
        dv_nlo_q[0][i] <= numn_q[i][QUO_W-1:0];
      end
      dv_quo_q[0]  <= '0;
    end
  end

  for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
    logic [LANES-1:0][DEN_W:0]   remx;
    logic [LANES-1:0][DEN_W:0]   diff;
    logic [LANES-1:0]            ge;
    logic [LANES-1:0][DEN_W-1:0] rem_d;
    logic [LANES-1:0][QUO_W-1:0] quo_d;

    always_comb begin
      for (int i = 0; i < LANES; i++) begin
        remx[i]  = {dv_rem_q[j][i], dv_nlo_q[j][i][QUO_W-1-j]};
        diff[i]  = remx[i] - {1'b0, dv_den_q[j][i]};
        ge[i]    = (remx[i] >= {1'b0, dv_den_q[j][i]});
        rem_d[i] = ge[i] ? diff[i][DEN_W-1:0] : remx[i][DEN_W-1:0];
        quo_d[i] = {dv_quo_q[j][i][QUO_W-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[j+1]  <= rem_d;
        dv_quo_q[j+1]  <= quo_d;
        dv_den_q[j+1]  <= dv_den_q[j];
        dv_nlo_q[j+1]  <= dv_nlo_q[j];
        dv_side_q[j+1] <= dv_side_q[j];
      end
    end
  end

  // ---------------- Output register ----------------
  dv_side_t                    dv_end;
  logic [LANES-1:0][QUO_W-1:0] quo_sat;
  logic [LANES-1:0][31:0]      contact_d;
  logic [31:0]                 time_d;
  logic [1:0]                  status_q;
  logic [LANES-1:0][31:0]      contact_q;
  logic [31:0]                 time_q;

  assign dv_end = dv_side_q[DV_STEPS];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      quo_sat[i]   = dv_end.sat[i] ? TIME_MAX : dv_quo_q[DV_STEPS][i];
      contact_d[i] = 32'd0;
      if (dv_end.status == ST_OVERLAP && !dv_end.ss_zero) begin
        contact_d[i] = signed_clamp(quo_sat[i], dv_end.neg[i]);
      end
    end
    case (dv_end.status)
      ST_OVERLAP:  time_d = 32'd0;
      ST_IMPACT:   time_d = quo_sat[0];
      ST_SEPARATE: time_d = dv_end.time_pre;
      ST_MISS:     time_d = dv_end.time_pre;
      default:     time_d = dv_end.time_pre;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v_q[DV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q  <= dv_end.status;
      contact_q <= contact_d;
      time_q    <= time_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.contact_x   = contact_q[0];
  assign out_o.contact_y   = contact_q[1];
  assign out_o.contact_z   = contact_q[2];
  assign out_o.impact_time = time_q;

`ifndef SYNTH
  // A held result freezes the whole pipe, including the last divider stage
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(dv_v_q[DV_STEPS])))
    else $error("pipeline moved while output stalled");

  // Contact point is only reported on overlap
  a_contact_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OVERLAP) |->
      (out_o.contact_x == 32'd0 && out_o.contact_y == 32'd0 && out_o.contact_z == 32'd0))
    else $error("nonzero contact outside overlap");

  // Overlap reports time zero
  a_overlap_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_OVERLAP) |-> (out_o.impact_time == 32'd0))
    else $error("overlap with nonzero time");
`endif

endmodule

`default_nettype wire
